>>> design/iprl_pkg.sv
// Package for the IPv4 range location lookup: shared types, constants and codes.
// Used by the controller, the datapath, the top level and the checker.
`default_nettype none

package iprl_pkg;

	// Default database size in 32-bit words
	localparam int unsigned MEM_WORDS_DEF = 1048576;

	// Word read address width; covers every record and table word
	localparam int unsigned RADDR_W = 24;

	// Field widths
	localparam int unsigned WADDR_W = 20;
	localparam int unsigned DATA_W  = 32;
	localparam int unsigned BYTE_W  = 23;
	localparam int unsigned LEN_W   = 8;
	localparam int unsigned OFF_W   = 24;

	// Record area layout
	localparam logic [BYTE_W-1:0] RECORD_BIAS  = BYTE_W'(1024);
	localparam logic [BYTE_W-1:0] RECORD_BYTES = BYTE_W'(8);

	// Operation codes on the func field
	localparam logic FUNC_WRITE  = 1'b0;
	localparam logic FUNC_LOOKUP = 1'b1;

	// Configuration register indexes
	localparam logic CFG_INDEX_END   = 1'b0;
	localparam logic CFG_FILE_LENGTH = 1'b1;

	typedef struct packed {
		logic               func;
		logic [WADDR_W-1:0] word_address;
		logic [DATA_W-1:0]  word_data;
		logic [DATA_W-1:0]  ip;
	} req_word_t;

	typedef struct packed {
		logic              found;
		logic [BYTE_W-1:0] text_address;
		logic [LEN_W-1:0]  text_length;
	} rsp_word_t;

	// Controller to datapath commands
	typedef struct packed {
		logic write_word;
		logic lookup_start;
		logic load_pos;
		logic read_word0;
		logic read_word1;
		logic take_record;
		logic next_pos;
		logic emit;
	} ctrl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic pos_in_range;
		logic end_match;
	} dp_status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TABLE,
		ST_SCAN,
		ST_REC0,
		ST_REC1,
		ST_FINISH
	} ctrl_state_t;

endpackage

`default_nettype wire

>>> design/ipv4_range_location_lookup.sv
// IPv4 range location lookup, top level: sequencer plus datapath.
// Depends on iprl_pkg, iprl_ctrl and iprl_dpath.
//
// A word with func at write stores one 32-bit database word in the same cycle and
// leaves the block free. A lookup reads the start index from the table entry of
// the top octet, then scans 8-byte records through the single memory read port,
// each with a bound check, an end-address read and a text-field read. The result
// strobe done is registered from a finish state, reached when the bound check
// fails or when a record matches; busy stays high until the cycle of the strobe,
// when a new word can be taken. Results are shown for exactly one cycle and cannot
// be held off. Configuration writes (index_end, file_length) are taken at once and
// should be made while idle.
`default_nettype none

module ipv4_range_location_lookup #(
	parameter int unsigned MEM_WORDS = iprl_pkg::MEM_WORDS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire iprl_pkg::req_word_t          request,
	output logic                              done,
	output iprl_pkg::rsp_word_t               result,
	input  wire logic                         cfg_we,
	input  wire logic                         cfg_index,
	input  wire logic [iprl_pkg::BYTE_W-1:0]  cfg_data
);

	iprl_pkg::ctrl_cmd_t  cmd;
	iprl_pkg::dp_status_t status;

	// Sequencer
	iprl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (request.func),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Memory and scan datapath
	iprl_dpath #(
		.MEM_WORDS (MEM_WORDS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.request   (request),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.status    (status),
		.result    (result),
		.done      (done)
	);

endmodule

`default_nettype wire

>>> design/iprl_ctrl.sv
// Lookup sequencer for the IPv4 range location lookup.
// Depends on iprl_pkg; drives the datapath through ctrl_cmd_t and reads dp_status_t.
`default_nettype none

module iprl_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic                 func,
	input  wire iprl_pkg::dp_status_t status,
	output iprl_pkg::ctrl_cmd_t       cmd,
	output logic                      busy
);

	iprl_pkg::ctrl_state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= iprl_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		unique case (state_q)
			iprl_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					if (func == iprl_pkg::FUNC_LOOKUP) begin
						cmd.lookup_start = 1'b1;
						state_d          = iprl_pkg::ST_TABLE;
					end else begin
						cmd.write_word = 1'b1;
					end
				end
			end
			iprl_pkg::ST_TABLE: begin
				cmd.load_pos = 1'b1;
				state_d      = iprl_pkg::ST_SCAN;
			end
			iprl_pkg::ST_SCAN: begin
				if (status.pos_in_range) begin
					cmd.read_word0 = 1'b1;
					state_d        = iprl_pkg::ST_REC0;
				end else begin
					state_d = iprl_pkg::ST_FINISH;
				end
			end
			iprl_pkg::ST_REC0: begin
				cmd.read_word1 = 1'b1;
				state_d        = iprl_pkg::ST_REC1;
			end
			iprl_pkg::ST_REC1: begin
				if (status.end_match) begin
					cmd.take_record = 1'b1;
					state_d         = iprl_pkg::ST_FINISH;
				end else begin
					cmd.next_pos = 1'b1;
					state_d      = iprl_pkg::ST_SCAN;
				end
			end
			iprl_pkg::ST_FINISH: begin
				cmd.emit = 1'b1;
				state_d  = iprl_pkg::ST_IDLE;
			end
			default: begin
				state_d = iprl_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> design/iprl_dpath.sv
// Datapath of the IPv4 range location lookup: database memory, configuration
// registers, scan position, record decode and result register. Depends on iprl_pkg.
`default_nettype none

module iprl_dpath #(
	parameter int unsigned MEM_WORDS = iprl_pkg::MEM_WORDS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire iprl_pkg::ctrl_cmd_t               cmd,
	input  wire iprl_pkg::req_word_t               request,
	input  wire logic                              cfg_we,
	input  wire logic                              cfg_index,
	input  wire logic [iprl_pkg::BYTE_W-1:0]       cfg_data,
	output iprl_pkg::dp_status_t                   status,
	output iprl_pkg::rsp_word_t                    result,
	output logic                                   done
);

	localparam int unsigned AW = $clog2(MEM_WORDS);
	localparam int unsigned BW = iprl_pkg::BYTE_W;
	localparam int unsigned LIM_W = iprl_pkg::RADDR_W + 1;
	localparam logic [LIM_W-1:0] MEM_LIMIT = LIM_W'(MEM_WORDS);

	logic [iprl_pkg::DATA_W-1:0] mem_q [MEM_WORDS];

	logic [BW-1:0]                   index_end_q, file_length_q;
	logic [iprl_pkg::DATA_W-1:0]     ip_q;
	logic [BW-1:0]                   pos_q;
	logic [iprl_pkg::DATA_W-1:0]     rdata_q;
	logic                            rd_ok_q;
	logic                            end_match_q;
	logic                            matched_q;
	logic                            off_zero_q;
	logic [BW+1:0]                   addr_q;
	logic [iprl_pkg::LEN_W-1:0]      len_q;
	iprl_pkg::rsp_word_t             result_q;
	logic                            done_q;

	logic [iprl_pkg::RADDR_W-1:0]    rd_addr;
	logic                            rd_en;
	logic [iprl_pkg::RADDR_W-1:0]    wr_addr;
	logic                            wr_ok;
	logic [iprl_pkg::DATA_W-1:0]     rword;
	logic [iprl_pkg::DATA_W-1:0]     start_index;
	logic [iprl_pkg::OFF_W-1:0]      text_off;
	logic [BW-1:0]                   limit;
	logic [BW+2:0]                   text_end;
	logic                            found;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_end_q   <= '0;
			file_length_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				iprl_pkg::CFG_INDEX_END:   index_end_q   <= cfg_data;
				iprl_pkg::CFG_FILE_LENGTH: file_length_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Write port: drop words beyond the memory
	assign wr_addr = iprl_pkg::RADDR_W'(request.word_address);
	assign wr_ok   = {1'b0, wr_addr} < MEM_LIMIT;

	always_ff @(posedge clk) begin
		if (cmd.write_word && wr_ok) begin
			mem_q[wr_addr[AW-1:0]] <= request.word_data;
		end
	end

	// Read address: table word 1+octet, record words 1+pos/4 and 2+pos/4
	always_comb begin
		rd_en   = cmd.lookup_start | cmd.read_word0 | cmd.read_word1;
		rd_addr = '0;
		priority if (cmd.lookup_start) begin
			rd_addr = iprl_pkg::RADDR_W'(request.ip[31:24]) + iprl_pkg::RADDR_W'(1);
		end else if (cmd.read_word0) begin
			rd_addr = iprl_pkg::RADDR_W'(pos_q[BW-1:2]) + iprl_pkg::RADDR_W'(1);
		end else if (cmd.read_word1) begin
			rd_addr = iprl_pkg::RADDR_W'(pos_q[BW-1:2]) + iprl_pkg::RADDR_W'(2);
		end else begin
			rd_addr = '0;
		end
	end

	// Registered read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem_q[rd_addr[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ok_q <= 1'b0;
		end else if (rd_en) begin
			rd_ok_q <= {1'b0, rd_addr} < MEM_LIMIT;
		end
	end

	// Words beyond the memory read as zero
	assign rword = rd_ok_q ? rdata_q : '0;

	// Little-endian decode of the table entry and the text offset
	assign start_index = {rword[7:0], rword[15:8], rword[23:16], rword[31:24]};
	assign text_off    = {rword[15:8], rword[23:16], rword[31:24]};

	// Scan bound
	assign limit = (index_end_q >= iprl_pkg::RECORD_BIAS) ?
		(index_end_q - iprl_pkg::RECORD_BIAS) : '0;
	assign status.pos_in_range = pos_q < limit;
	assign status.end_match    = end_match_q;

	// Scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matched_q <= 1'b0;
		end else if (cmd.lookup_start) begin
			matched_q <= 1'b0;
		end else if (cmd.take_record) begin
			matched_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.lookup_start) begin
			ip_q <= request.ip;
		end
		// Start index with a bit set at bit 19 or above: park past the bound
		if (cmd.load_pos) begin
			if (start_index[31:BW-4] != '0) begin
				pos_q <= '1;
			end else begin
				pos_q <= {start_index[BW-5:0], 3'b000} + iprl_pkg::RECORD_BIAS;
			end
		end else if (cmd.next_pos) begin
			pos_q <= pos_q + iprl_pkg::RECORD_BYTES;
		end
		if (cmd.read_word1) begin
			end_match_q <= rword >= ip_q;
		end
		if (cmd.take_record) begin
			off_zero_q <= text_off == '0;
			addr_q     <= (BW+2)'(index_end_q) + (BW+2)'(text_off)
				- (BW+2)'(iprl_pkg::RECORD_BIAS);
			len_q      <= rword[7:0];
		end
	end

	// Bounds check of the text against the file length
	assign text_end = {1'b0, addr_q} + (BW+3)'(len_q);
	assign found    = matched_q && !off_zero_q && (text_end <= (BW+3)'(file_length_q));

	// Result register and strobe
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			result_q.found        <= found;
			result_q.text_address <= found ? addr_q[BW-1:0] : '0;
			result_q.text_length  <= found ? len_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit;
		end
	end

	assign result = result_q;
	assign done   = done_q;

endmodule

`default_nettype wire

>>> design/iprl_checker.sv
// Port-level checker for the IPv4 range location lookup, bound to the top level.
// Depends on iprl_pkg.
`default_nettype none

module iprl_checker (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 start,
	input wire logic                 busy,
	input wire iprl_pkg::req_word_t  request,
	input wire logic                 done,
	input wire iprl_pkg::rsp_word_t  result
);

	// A lookup word holds the block busy
	a_lookup_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && request.func == iprl_pkg::FUNC_LOOKUP |=> busy)
		else $error("lookup accepted but block not busy");

	// A memory write leaves the block free
	a_write_free: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && request.func == iprl_pkg::FUNC_WRITE |=> !busy && !done)
		else $error("memory write occupied the block");

	// A result ends the lookup and never repeats in the next cycle
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy))
		else $error("result strobe outside the end of a lookup");

	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("back-to-back result strobes");

	// An unknown location carries zero address and length
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.found |-> result.text_address == '0 && result.text_length == '0)
		else $error("miss result with nonzero fields");

endmodule

bind ipv4_range_location_lookup iprl_checker u_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.request (request),
	.done    (done),
	.result  (result)
);

`default_nettype wire

>>> tb/sv/ipv4_range_location_lookup_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for ipv4_range_location_lookup: loads a small range database,
// runs directed and random words over several register settings, checks every result.
// Depends on iprl_pkg and the block's RTL.
module ipv4_range_location_lookup_tb;

	localparam int unsigned NREC            = 48;
	localparam int unsigned TABLE_WORD0     = 1;
	localparam int unsigned REC_WORD0       = 257;
	localparam logic [iprl_pkg::BYTE_W-1:0] FULL_INDEX_END = 23'd2432;
	localparam int unsigned SCAN_CAP        = 64;
	localparam int unsigned SETTLE_CYCLES   = 8;
	localparam int unsigned DRAIN_CYCLES    = 16;
	localparam int unsigned WATCHDOG_LIMIT  = 4000;
	localparam int unsigned PHASE_WORDS     = 95;
	localparam int unsigned PHASES          = 8;
	localparam iprl_pkg::rsp_word_t NOT_FOUND = '0;

	typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

	typedef struct packed {
		row_kind_t                   kind;
		logic                        cfg_sel;
		logic [iprl_pkg::BYTE_W-1:0] cfg_val;
		iprl_pkg::req_word_t         word;
		logic                        typed;
		iprl_pkg::rsp_word_t         loc;
	} plan_row_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        start = 1'b0;
	logic                        busy;
	iprl_pkg::req_word_t         request = '0;
	logic                        done;
	iprl_pkg::rsp_word_t         result;
	logic                        cfg_we = 1'b0;
	logic                        cfg_index = iprl_pkg::CFG_INDEX_END;
	logic [iprl_pkg::BYTE_W-1:0] cfg_data = '0;

	// Shadow of the database image and registers
	logic [31:0]                 db_image [longint unsigned];
	logic [iprl_pkg::BYTE_W-1:0] cur_index_end = '0;
	logic [iprl_pkg::BYTE_W-1:0] cur_file_length = '0;
	iprl_pkg::rsp_word_t         pending_locations [$];
	int                          fail_count = 0;
	int                          idle_cycles = 0;
	bit                          gaps_on = 1'b1;

	ipv4_range_location_lookup DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// 8 ns clock
	always #4 clk = ~clk;

	// Table entry: start index stored little-endian, first file byte on top
	function automatic logic [31:0] table_word(input logic [31:0] first);
		return {first[7:0], first[15:8], first[23:16], first[31:24]};
	endfunction

	// Record text field: 3-byte little-endian offset, then the length byte
	function automatic logic [31:0] text_word(input logic [23:0] off, input logic [7:0] len);
		return {off[7:0], off[15:8], off[23:16], len};
	endfunction

	function automatic logic [31:0] random_text();
		logic [23:0] off;
		logic [7:0]  len;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 10)
			off = '0;
		else if (pick < 20)
			off = 24'($urandom);
		else
			off = 24'($urandom_range(1, 1500));
		len = ($urandom_range(99) < 5) ? 8'hFF : 8'($urandom);
		return text_word(off, len);
	endfunction

	function automatic iprl_pkg::req_word_t lookup_word(input logic [31:0] ip);
		iprl_pkg::req_word_t w;
		w.func = iprl_pkg::FUNC_LOOKUP;
		w.word_address = iprl_pkg::WADDR_W'($urandom);
		w.word_data = $urandom;
		w.ip = ip;
		return w;
	endfunction

	function automatic iprl_pkg::req_word_t store_word(input int unsigned addr,
			input logic [31:0] data);
		iprl_pkg::req_word_t w;
		w.func = iprl_pkg::FUNC_WRITE;
		w.word_address = iprl_pkg::WADDR_W'(addr);
		w.word_data = data;
		w.ip = $urandom;
		return w;
	endfunction

	function automatic iprl_pkg::rsp_word_t make_loc(input logic [iprl_pkg::BYTE_W-1:0] addr,
			input logic [iprl_pkg::LEN_W-1:0] len);
		iprl_pkg::rsp_word_t r;
		r.found = 1'b1;
		r.text_address = addr;
		r.text_length = len;
		return r;
	endfunction

	function automatic plan_row_t word_row(input iprl_pkg::req_word_t w, input logic typed,
			input iprl_pkg::rsp_word_t loc);
		plan_row_t row;
		row = '0;
		row.kind = ROW_WORD;
		row.word = w;
		row.typed = typed;
		row.loc = loc;
		return row;
	endfunction

	function automatic plan_row_t reg_row(input logic sel,
			input logic [iprl_pkg::BYTE_W-1:0] val);
		plan_row_t row;
		row = '0;
		row.kind = ROW_REG;
		row.cfg_sel = sel;
		row.cfg_val = val;
		return row;
	endfunction

	// First record whose range end covers the octet; the last record catches the rest
	function automatic int unsigned first_record(input logic [7:0] t);
		for (int unsigned r = 0; r < NREC; r++)
			if (db_image.exists(REC_WORD0 + 2 * r) && db_image[REC_WORD0 + 2 * r] >= {t, 24'h0})
				return r;
		return NREC - 1;
	endfunction

	// Fetch one image word; flag a read of a word that was never stored
	function automatic logic [31:0] image_word(input longint unsigned w, inout bit safe);
		if (w >= iprl_pkg::MEM_WORDS_DEF)
			return '0;
		if (!db_image.exists(w)) begin
			safe = 1'b0;
			return '0;
		end
		return db_image[w];
	endfunction

	// Walk the range table for one address; returns 0 if the walk is not usable as stimulus
	function automatic bit predict_location(input logic [31:0] ip,
			output iprl_pkg::rsp_word_t loc);
		longint unsigned pos, limit, first, rec_w, txt_addr;
		logic [31:0]     tword, eword, xword;
		logic [23:0]     off;
		logic [7:0]      len;
		bit              hit, safe;
		int unsigned     steps;
		loc = NOT_FOUND;
		hit = 1'b0;
		safe = 1'b1;
		steps = 0;
		off = '0;
		len = '0;
		tword = image_word(TABLE_WORD0 + ip[31:24], safe);
		first = {tword[7:0], tword[15:8], tword[23:16], tword[31:24]};
		limit = 0;
		if (cur_index_end >= 1024)
			limit = cur_index_end - 23'd1024;
		for (pos = first * 8 + 1024; pos < limit && !hit && steps <= SCAN_CAP; pos += 8) begin
			rec_w = (pos + 4) >> 2;
			eword = image_word(rec_w, safe);
			xword = image_word(rec_w + 1, safe);
			steps++;
			if (eword >= ip) begin
				hit = 1'b1;
				off = {xword[15:8], xword[23:16], xword[31:24]};
				len = xword[7:0];
			end
		end
		if (steps > SCAN_CAP)
			safe = 1'b0;
		if (hit && off != 0) begin
			txt_addr = cur_index_end;
			txt_addr = txt_addr + off - 1024;
			if (txt_addr + len <= cur_file_length)
				loc = make_loc(txt_addr[iprl_pkg::BYTE_W-1:0], len);
		end
		return safe;
	endfunction

	// Hand one word to the block and record its effect once it is taken
	task automatic issue_word(input iprl_pkg::req_word_t w, input logic typed,
			input iprl_pkg::rsp_word_t typed_loc);
		iprl_pkg::rsp_word_t loc;
		// Idle the sender at random before the word while gaps are on
		while (gaps_on && $urandom_range(99) < 37) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		request <= w;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (w.func == iprl_pkg::FUNC_WRITE) begin
			db_image[w.word_address] = w.word_data;
		end else begin
			void'(predict_location(w.ip, loc));
			pending_locations.push_back(typed ? typed_loc : loc);
		end
	endtask

	// Write a register once the block has drained
	task automatic write_register(input logic sel, input logic [iprl_pkg::BYTE_W-1:0] val);
		start <= 1'b0;
		do @(posedge clk); while (pending_locations.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= sel;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (sel == iprl_pkg::CFG_INDEX_END)
			cur_index_end = val;
		else
			cur_file_length = val;
	endtask

	// Compare each result word with the oldest prediction
	always @(posedge clk) begin : check_results
		iprl_pkg::rsp_word_t want;
		if (arst_n && done) begin
			if (pending_locations.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected result: found=%0b addr=%0d len=%0d",
						result.found, result.text_address, result.text_length);
			end else begin
				want = pending_locations.pop_front();
				if (want.found !== result.found || want.text_address !== result.text_address
						|| want.text_length !== result.text_length) begin
					fail_count++;
					if (fail_count <= 10)
						$display({"mismatch: expected found=%0b addr=%0d len=%0d,",
							" got found=%0b addr=%0d len=%0d"},
							want.found, want.text_address, want.text_length,
							result.found, result.text_address, result.text_length);
				end
			end
		end
	end

	// Abort when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		plan_row_t                   plan [$];
		logic [31:0]                 ip, end_w, first;
		logic [iprl_pkg::BYTE_W-1:0] phase_ie, phase_fl;
		iprl_pkg::rsp_word_t         loc;
		bit                          ok;
		int unsigned                 r, t, roll, tries;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Load the image: header, ascending range records, then the octet table
		issue_word(store_word(0, $urandom), 1'b0, NOT_FOUND);
		for (r = 0; r < NREC; r++) begin
			end_w = (r == NREC - 1) ? 32'hFFFF_FFFF :
				r * 32'd89478485 + $urandom_range(0, 89478484);
			issue_word(store_word(REC_WORD0 + 2 * r, end_w), 1'b0, NOT_FOUND);
			issue_word(store_word(REC_WORD0 + 2 * r + 1,
				(r == 0) ? text_word(24'd5, 8'd10) : random_text()), 1'b0, NOT_FOUND);
		end
		for (t = 0; t < 256; t++)
			issue_word(store_word(TABLE_WORD0 + t, table_word(first_record(t))), 1'b0, NOT_FOUND);

		// Directed words; record 0 covers address 0 and points at offset 5, length 10
		plan.push_back(word_row(lookup_word(32'h0), 1'b1, NOT_FOUND));
		plan.push_back(word_row(lookup_word(32'hFFFF_FFFF), 1'b1, NOT_FOUND));
		plan.push_back(reg_row(iprl_pkg::CFG_INDEX_END, 23'd1023));
		plan.push_back(word_row(lookup_word(32'h8000_0000), 1'b1, NOT_FOUND));
		plan.push_back(reg_row(iprl_pkg::CFG_INDEX_END, 23'd1024));
		plan.push_back(word_row(lookup_word(32'h0), 1'b1, NOT_FOUND));
		plan.push_back(reg_row(iprl_pkg::CFG_INDEX_END, FULL_INDEX_END));
		plan.push_back(reg_row(iprl_pkg::CFG_FILE_LENGTH, 23'h7F_FFFF));
		plan.push_back(word_row(lookup_word(32'h0), 1'b1, make_loc(23'd1413, 8'd10)));
		plan.push_back(word_row(lookup_word(32'hFFFF_FFFF), 1'b0, NOT_FOUND));
		plan.push_back(word_row(lookup_word(32'h5A3C_96E1), 1'b0, NOT_FOUND));
		// zero text offset
		plan.push_back(word_row(store_word(REC_WORD0 + 1, text_word(24'd0, 8'd20)), 1'b0,
			NOT_FOUND));
		plan.push_back(word_row(lookup_word(32'h0), 1'b1, NOT_FOUND));
		// text runs past the end of the file
		plan.push_back(word_row(store_word(REC_WORD0 + 1, text_word(24'hFF_FFFF, 8'hFF)), 1'b0,
			NOT_FOUND));
		plan.push_back(word_row(lookup_word(32'h0), 1'b1, NOT_FOUND));
		// text ending one byte past, then exactly at, the file length
		plan.push_back(word_row(store_word(REC_WORD0 + 1, text_word(24'd1, 8'd1)), 1'b0,
			NOT_FOUND));
		plan.push_back(reg_row(iprl_pkg::CFG_FILE_LENGTH, 23'd1409));
		plan.push_back(word_row(lookup_word(32'h0), 1'b1, NOT_FOUND));
		plan.push_back(reg_row(iprl_pkg::CFG_FILE_LENGTH, 23'd1410));
		plan.push_back(word_row(lookup_word(32'h0), 1'b1, make_loc(23'd1409, 8'd1)));
		// start index far past, then exactly at, the scan bound
		plan.push_back(word_row(store_word(TABLE_WORD0, table_word(32'hFFFF_FFFF)), 1'b0,
			NOT_FOUND));
		plan.push_back(word_row(lookup_word(32'h0), 1'b1, NOT_FOUND));
		plan.push_back(word_row(store_word(TABLE_WORD0, table_word(NREC)), 1'b0, NOT_FOUND));
		plan.push_back(word_row(lookup_word(32'h0), 1'b1, NOT_FOUND));
		// record beyond the memory reads as zero: matches address 0 with a zero offset
		plan.push_back(reg_row(iprl_pkg::CFG_INDEX_END, 23'h7F_FFFF));
		plan.push_back(word_row(store_word(TABLE_WORD0, table_word(32'd524160)), 1'b0,
			NOT_FOUND));
		plan.push_back(word_row(lookup_word(32'h0), 1'b1, NOT_FOUND));
		// address and data extremes on the header and the top word
		plan.push_back(word_row(store_word(0, 32'hFFFF_FFFF), 1'b0, NOT_FOUND));
		plan.push_back(word_row(store_word(20'hF_FFFF, 32'h0), 1'b0, NOT_FOUND));
		plan.push_back(word_row(store_word(0, 32'h0), 1'b0, NOT_FOUND));
		// restore record 0 and its table entry
		plan.push_back(word_row(store_word(TABLE_WORD0, table_word(32'd0)), 1'b0, NOT_FOUND));
		plan.push_back(word_row(store_word(REC_WORD0 + 1, text_word(24'd5, 8'd10)), 1'b0,
			NOT_FOUND));
		plan.push_back(reg_row(iprl_pkg::CFG_FILE_LENGTH, 23'h7F_FFFF));
		plan.push_back(word_row(lookup_word(32'h0), 1'b1, make_loc(23'd8387588, 8'd10)));
		plan.push_back(word_row(lookup_word(32'hFFFF_FFFF), 1'b0, NOT_FOUND));

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_REG)
				write_register(plan[i].cfg_sel, plan[i].cfg_val);
			else
				issue_word(plan[i].word, plan[i].typed, plan[i].loc);
		end

		// Random words over a series of register settings
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin phase_ie = FULL_INDEX_END; phase_fl = 23'd4194304; end
				1: begin phase_ie = FULL_INDEX_END; phase_fl = 23'd3000; end
				2: begin phase_ie = 23'd2200; phase_fl = 23'd4194304; end
				3: begin phase_ie = 23'h7F_FFFF; phase_fl = 23'h7F_FFFF; end
				4: begin phase_ie = 23'd4194304; phase_fl = 23'd4194304; end
				5: begin phase_ie = 23'd1023; phase_fl = 23'h7F_FFFF; end
				6: begin phase_ie = 23'd2048; phase_fl = 23'd0; end
				default: begin
					phase_ie = iprl_pkg::BYTE_W'(32'd2048 + $urandom_range(0, 500));
					phase_fl = iprl_pkg::BYTE_W'($urandom_range(0, 8000));
				end
			endcase
			write_register(iprl_pkg::CFG_INDEX_END, phase_ie);
			write_register(iprl_pkg::CFG_FILE_LENGTH, phase_fl);
			// one long stretch with the sender never pausing
			gaps_on = (p != 2);
			repeat (PHASE_WORDS) begin
				roll = $urandom_range(99);
				r = $urandom_range(0, NREC - 1);
				if (roll < 65) begin
					// lookup near a range end or anywhere; skip walks over unloaded words
					ok = 1'b0;
					for (tries = 0; tries < 16 && !ok; tries++) begin
						if ($urandom_range(99) < 55)
							ip = db_image[REC_WORD0 + 2 * r] + 32'($urandom_range(0, 4)) - 32'd2;
						else
							ip = $urandom;
						ok = predict_location(ip, loc);
						r = $urandom_range(0, NREC - 1);
					end
					if (ok)
						issue_word(lookup_word(ip), 1'b0, NOT_FOUND);
					else
						issue_word(store_word(REC_WORD0 + 2 * r + 1, random_text()), 1'b0, NOT_FOUND);
				end else if (roll < 75) begin
					issue_word(store_word(REC_WORD0 + 2 * r + 1, random_text()), 1'b0, NOT_FOUND);
				end else if (roll < 82) begin
					// drift one range end; keep the all-ones last record in place
					r = $urandom_range(0, NREC - 2);
					issue_word(store_word(REC_WORD0 + 2 * r, $urandom), 1'b0, NOT_FOUND);
				end else if (roll < 92) begin
					t = $urandom_range(0, 255);
					roll = $urandom_range(99);
					if (roll < 60)
						first = first_record(t);
					else if (roll < 85)
						first = $urandom_range(0, NREC);
					else
						first = $urandom;
					issue_word(store_word(TABLE_WORD0 + t, table_word(first)), 1'b0, NOT_FOUND);
				end else begin
					issue_word(store_word($urandom, $urandom), 1'b0, NOT_FOUND);
				end
			end
		end

		// Drain, then report
		start <= 1'b0;
		while (pending_locations.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		fail_count += pending_locations.size();
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
